### hdl/amavg_pkg.sv
// package for the adjustable moving-average filter
// operation codes, default sizes and shared status types; no dependencies
package amavg_pkg;

	localparam int HISTORY_DEPTH_DEF = 50;
	localparam int SAMPLE_WIDTH_DEF  = 16;
	localparam int WINDOW_OUT_W      = 6;
	localparam int OP_W              = 2;

	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_WIDEN  = 2'd1;
	localparam logic [OP_W-1:0] OP_NARROW = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

### hdl/amavg_ifs.sv
// request and result channels of the moving-average filter
// depends on amavg_pkg
interface amavg_item_if import amavg_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic [OP_W-1:0]                operation;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, operation, sample, input ready);
	modport sink   (input valid, operation, sample, output ready);
endinterface

interface amavg_result_if import amavg_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] average;
	logic [WINDOW_OUT_W-1:0]        window_used;

	modport source (output valid, average, window_used, input ready);
	modport sink   (input valid, average, window_used, output ready);
endinterface

### hdl/adjustable_moving_average.sv
// adjustable moving-average filter: a sample request shifts its sample into the cell chain;
// one full turn of the cell chain then sums the window, then one divider step per bit of the sum
// gives the result; the next request is taken only after that result is loaded, and the load
// waits while an earlier result is still unread; widen and narrow requests are handled as they
// are taken, without leaving idle; one request in flight at a time
// reset (arst_n low, asynchronous) clears the history to zero and sets the window to one
module adjustable_moving_average import amavg_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	amavg_item_if.sink       item,
	amavg_result_if.source   result
);

	localparam int IDX_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = SAMPLE_WIDTH + IDX_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ROT   = 4'b0010,
		S_START = 4'b0100,
		S_DIV   = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [IDX_W-1:0]               win_q;
	logic [IDX_W-1:0]               rot_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] avg_q;
	logic [WINDOW_OUT_W-1:0]        win_out_q;

	logic                           accept;
	logic                           push;
	logic                           shift;
	logic                           in_window;
	logic                           load_out;
	logic signed [SAMPLE_WIDTH-1:0] head_d;
	logic signed [SAMPLE_WIDTH-1:0] tap;
	logic signed [SUM_W-1:0]        quotient;
	div_status_t                    div_status;
	logic [IDX_W+WINDOW_OUT_W-1:0]  win_ext;

	logic signed [SAMPLE_WIDTH-1:0] chain [HISTORY_DEPTH];

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign push       = accept && (item.operation == OP_SAMPLE);
	assign shift      = push || (state_q == S_ROT);
	assign head_d     = (state_q == S_IDLE) ? item.sample : chain[HISTORY_DEPTH-1];
	assign tap        = chain[HISTORY_DEPTH-1];
	assign in_window  = ({1'b0, rot_q} + {1'b0, win_q}) >= (IDX_W + 1)'(HISTORY_DEPTH);
	assign load_out   = (state_q == S_DIV) && div_status.done
		&& (!out_valid_q || result.ready);
	assign win_ext    = {{WINDOW_OUT_W{1'b0}}, win_q};

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		amavg_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.data_in ((i == 0) ? head_d : chain[(i == 0) ? 0 : i - 1]),
			.data_out(chain[i])
		);
	end

	amavg_div #(
		.SUM_W(SUM_W),
		.WIN_W(IDX_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_START),
		.dividend(sum_q),
		.divisor (win_q),
		.quotient(quotient),
		.status  (div_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			win_q   <= IDX_W'(1);
			rot_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					rot_q <= '0;
					if (accept) begin
						case (item.operation)
							OP_SAMPLE: state_q <= S_ROT;
							OP_WIDEN: begin
								if (win_q < IDX_W'(HISTORY_DEPTH)) begin
									win_q <= win_q + 1'b1;
								end
							end
							OP_NARROW: begin
								if (win_q > IDX_W'(1)) begin
									win_q <= win_q - 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_ROT: begin
					rot_q <= rot_q + 1'b1;
					if (rot_q == IDX_W'(HISTORY_DEPTH - 1)) begin
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// window sum gathered as the newest entries pass the tail of the chain during the rotation
	always_ff @(posedge clk) begin
		if (push) begin
			sum_q <= '0;
		end else if (state_q == S_ROT && in_window) begin
			sum_q <= sum_q + {{(SUM_W - SAMPLE_WIDTH){tap[SAMPLE_WIDTH-1]}}, tap};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			avg_q     <= quotient[SAMPLE_WIDTH-1:0];
			win_out_q <= win_ext[WINDOW_OUT_W-1:0];
		end
	end

	assign result.valid       = out_valid_q;
	assign result.average     = avg_q;
	assign result.window_used = win_out_q;

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("filter state not one-hot");

	a_window_range: assert property (@(posedge clk) disable iff (!arst_n)
		win_q >= IDX_W'(1) && win_q <= IDX_W'(HISTORY_DEPTH))
		else $error("window length out of range");

	a_result_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DIV && div_status.done))
		else $error("result raised without a finished division");

	a_div_idle_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_ROT) |-> !div_status.busy)
		else $error("divider busy outside a division");
`endif

endmodule

### hdl/amavg_cell.sv
// one history cell of the shift/rotate chain
// depends on amavg_pkg
module amavg_cell import amavg_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           shift,
	input  logic signed [SAMPLE_WIDTH-1:0] data_in,
	output logic signed [SAMPLE_WIDTH-1:0] data_out
);

	logic signed [SAMPLE_WIDTH-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (shift) begin
			value_q <= data_in;
		end
	end

	assign data_out = value_q;

endmodule

### hdl/amavg_div.sv
// bit-serial signed divider, one quotient bit per cycle, positive divisor
// depends on amavg_pkg
module amavg_div import amavg_pkg::*; #(
	parameter int SUM_W = 22,
	parameter int WIN_W = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [WIN_W-1:0]        divisor,
	output logic signed [SUM_W-1:0] quotient,
	output div_status_t             status
);

	localparam int CW = (SUM_W > 1) ? $clog2(SUM_W) : 1;

	logic [SUM_W-1:0] quo_q;
	logic [WIN_W-1:0] rem_q;
	logic [WIN_W-1:0] divisor_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIN_W:0]   rem_sh;
	logic             ge;
	logic [WIN_W:0]   rem_nx;

	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign ge     = rem_sh >= {1'b0, divisor_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, divisor_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(SUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend[SUM_W-1] ? (-dividend) : dividend;
			neg_q     <= dividend[SUM_W-1];
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= rem_nx[WIN_W-1:0];
		end
	end

	assign quotient    = neg_q ? (-$signed(quo_q)) : $signed(quo_q);
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule
